// ===== src/ppm_p6_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// ppm p6 header parser assertion macros
// concurrent checks on clk with synchronous active-low reset rst_n
// ----------------------------------------------------------------------------
`ifndef PPM_P6_HEADER_PARSER_MACROS_SVH
`define PPM_P6_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define PPMHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm parser check failed");

// next-cycle implication
`define PPMHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm parser check failed");

`endif

// ===== src/ppmhp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmhp_pkg
// word types, character codes, result kinds and error codes of the parser
// ----------------------------------------------------------------------------
package ppmhp_pkg;

  // input word: one file byte plus end-of-file mark
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  pixel_byte;
    logic [2:0]  error_code;
    logic        final_res;
  } out_word_t;

  // parse core result
  typedef struct packed {
    logic      hit;
    out_word_t word;
  } res_t;

  // parse core status
  typedef struct packed {
    logic err_latched;
    logic data_phase;
  } status_t;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_SIG    = 3'd1;
  localparam logic [2:0] ERR_WIDTH  = 3'd2;
  localparam logic [2:0] ERR_HEIGHT = 3'd3;
  localparam logic [2:0] ERR_MAXVAL = 3'd4;
  localparam logic [2:0] ERR_NL     = 3'd5;
  localparam logic [2:0] ERR_DSIZE  = 3'd6;

  // character codes
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // only accepted max value
  localparam logic [7:0] MAX_VAL = 8'd255;

endpackage

// ===== src/ppmhp_parse.sv =====
// ----------------------------------------------------------------------------
// ppmhp_parse
// header parse state, data byte count and per-byte result decode
// ----------------------------------------------------------------------------
module ppmhp_parse #(
  parameter int MAX_DIM_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ppmhp_pkg::in_word_t in_word,
  output ppmhp_pkg::res_t     res,
  output ppmhp_pkg::status_t  status
);

  localparam int DW = MAX_DIM_BITS;
  localparam int AW = DW + 1;
  localparam int XW = DW + 5;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 2;
  localparam logic [AW-1:0] SAT_A = {1'b1, {DW{1'b0}}};
  localparam logic [XW-1:0] SAT_X = {4'b0, SAT_A};
  localparam logic [AW-1:0] MAX_A = {{(AW-8){1'b0}}, ppmhp_pkg::MAX_VAL};

  typedef enum logic [8:0] {
    PH_SIG0  = 9'b000000001,
    PH_SIG1  = 9'b000000010,
    PH_WSKIP = 9'b000000100,
    PH_WNUM  = 9'b000001000,
    PH_HSKIP = 9'b000010000,
    PH_HNUM  = 9'b000100000,
    PH_MSKIP = 9'b001000000,
    PH_MNUM  = 9'b010000000,
    PH_DATA  = 9'b100000000
  } phase_t;

  phase_t         phase_r, phase_nxt, f_phase;
  logic           comment_r, comment_nxt, f_comment;
  logic [AW-1:0]  acc_r, acc_nxt, f_acc;
  logic           neg_r, neg_nxt, f_neg;
  logic           seen_r, seen_nxt, f_seen;
  logic [DW-1:0]  width_r, width_nxt, f_width;
  logic [DW-1:0]  height_r, height_nxt, f_height;
  logic [RW-1:0]  rem_r, rem_nxt, f_rem;
  logic           err_r, err_nxt;
  logic [PW-1:0]  prod_r;

  logic [7:0]     c;
  logic           eof;
  logic [3:0]     dig;
  logic           is_digit, is_space, is_start;
  logic [XW-1:0]  acc_x10;
  logic [AW-1:0]  acc_dig;
  logic           dim_ok_r, max_ok_r, dim_ok_f, max_ok_f;
  logic [RW-1:0]  rem_load;

  logic           f_hit;
  logic [1:0]     f_kind;
  logic [2:0]     f_code;
  logic           do_skip;
  logic [2:0]     skip_code;
  phase_t         skip_next;

  logic           r_hit;
  logic [1:0]     r_kind;
  logic [2:0]     r_code;
  logic [DW+15:0] w_ext, h_ext;

  assign c   = in_word.byte_in;
  assign eof = in_word.end_of_file;
  assign dig = c[3:0];

  // character classes
  assign is_digit = (c >= ppmhp_pkg::CH_ZERO) && (c <= ppmhp_pkg::CH_NINE);
  assign is_space = (c == ppmhp_pkg::CH_SPACE) || (c == ppmhp_pkg::CH_TAB) ||
                    (c == ppmhp_pkg::CH_LF) || (c == ppmhp_pkg::CH_VT) ||
                    (c == ppmhp_pkg::CH_FF) || (c == ppmhp_pkg::CH_CR);
  assign is_start = is_digit || (c == ppmhp_pkg::CH_PLUS) || (c == ppmhp_pkg::CH_MINUS);

  // decimal accumulate with saturation at 2^MAX_DIM_BITS
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {{(XW-4){1'b0}}, dig};
  assign acc_dig = (acc_x10 > SAT_X) ? SAT_A : acc_x10[AW-1:0];

  // number checks, before and after this byte
  assign dim_ok_r = seen_r && !neg_r && (acc_r != '0) && !acc_r[DW];
  assign max_ok_r = seen_r && !neg_r && (acc_r == MAX_A);
  assign dim_ok_f = f_seen && !f_neg && (f_acc != '0) && !f_acc[DW];
  assign max_ok_f = f_seen && !f_neg && (f_acc == MAX_A);

  // data byte count: width * height * 3
  assign rem_load = {2'b0, prod_r} + {1'b0, prod_r, 1'b0};

  always_ff @(posedge clk) begin
    prod_r <= width_r * height_r;
  end

  // byte decode in the current phase
  always_comb begin
    f_phase   = phase_r;
    f_comment = comment_r;
    f_acc     = acc_r;
    f_neg     = neg_r;
    f_seen    = seen_r;
    f_width   = width_r;
    f_height  = height_r;
    f_rem     = rem_r;
    f_hit     = 1'b0;
    f_kind    = ppmhp_pkg::KIND_ERROR;
    f_code    = ppmhp_pkg::ERR_NONE;
    do_skip   = 1'b0;
    skip_code = ppmhp_pkg::ERR_NONE;
    skip_next = phase_r;
    unique case (phase_r)
      PH_SIG0: begin
        if (c != ppmhp_pkg::CH_P) begin
          f_hit  = 1'b1;
          f_code = ppmhp_pkg::ERR_SIG;
        end else begin
          f_phase = PH_SIG1;
        end
      end
      PH_SIG1: begin
        if (c != ppmhp_pkg::CH_SIX) begin
          f_hit  = 1'b1;
          f_code = ppmhp_pkg::ERR_SIG;
        end else begin
          f_phase = PH_WSKIP;
        end
      end
      PH_WSKIP: begin
        do_skip   = 1'b1;
        skip_code = ppmhp_pkg::ERR_WIDTH;
        skip_next = PH_WNUM;
      end
      PH_HSKIP: begin
        do_skip   = 1'b1;
        skip_code = ppmhp_pkg::ERR_HEIGHT;
        skip_next = PH_HNUM;
      end
      PH_MSKIP: begin
        do_skip   = 1'b1;
        skip_code = ppmhp_pkg::ERR_MAXVAL;
        skip_next = PH_MNUM;
      end
      PH_WNUM, PH_HNUM, PH_MNUM: begin
        if (is_digit) begin
          f_acc  = acc_dig;
          f_seen = 1'b1;
        end else if (phase_r == PH_MNUM) begin
          f_hit = 1'b1;
          if (!max_ok_r) begin
            f_code = ppmhp_pkg::ERR_MAXVAL;
          end else if (c != ppmhp_pkg::CH_LF) begin
            f_code = ppmhp_pkg::ERR_NL;
          end else begin
            f_kind  = ppmhp_pkg::KIND_HEADER;
            f_rem   = rem_load;
            f_phase = PH_DATA;
          end
        end else if (!dim_ok_r) begin
          f_hit  = 1'b1;
          f_code = (phase_r == PH_WNUM) ? ppmhp_pkg::ERR_WIDTH : ppmhp_pkg::ERR_HEIGHT;
        end else if (phase_r == PH_WNUM) begin
          // width done, terminator goes through the height skip
          f_width   = acc_r[DW-1:0];
          f_phase   = PH_HSKIP;
          do_skip   = 1'b1;
          skip_code = ppmhp_pkg::ERR_HEIGHT;
          skip_next = PH_HNUM;
        end else begin
          f_height  = acc_r[DW-1:0];
          f_phase   = PH_MSKIP;
          do_skip   = 1'b1;
          skip_code = ppmhp_pkg::ERR_MAXVAL;
          skip_next = PH_MNUM;
        end
      end
      PH_DATA: begin
        f_hit = 1'b1;
        if (rem_r == '0) begin
          f_code = ppmhp_pkg::ERR_DSIZE;
        end else begin
          f_kind = ppmhp_pkg::KIND_DATA;
          f_rem  = rem_r - RW'(1);
        end
      end
      default: begin
        f_phase = PH_SIG0;
      end
    endcase

    // whitespace and comment skip, number start
    if (do_skip) begin
      if (comment_r) begin
        if (c == ppmhp_pkg::CH_LF) begin
          f_comment = 1'b0;
        end
      end else if (c == ppmhp_pkg::CH_HASH) begin
        f_comment = 1'b1;
      end else if (is_space) begin
        f_comment = 1'b0;
      end else if (is_start) begin
        f_neg   = (c == ppmhp_pkg::CH_MINUS);
        f_seen  = is_digit;
        f_acc   = is_digit ? {{(AW-4){1'b0}}, dig} : '0;
        f_phase = skip_next;
      end else begin
        f_hit  = 1'b1;
        f_kind = ppmhp_pkg::KIND_ERROR;
        f_code = skip_code;
      end
    end
  end

  // end-of-file checks, error latch and next state
  always_comb begin
    r_hit       = 1'b0;
    r_kind      = f_kind;
    r_code      = f_code;
    phase_nxt   = f_phase;
    comment_nxt = f_comment;
    acc_nxt     = f_acc;
    neg_nxt     = f_neg;
    seen_nxt    = f_seen;
    width_nxt   = f_width;
    height_nxt  = f_height;
    rem_nxt     = f_rem;
    err_nxt     = err_r;
    if (err_r) begin
      phase_nxt   = phase_r;
      comment_nxt = comment_r;
      acc_nxt     = acc_r;
      neg_nxt     = neg_r;
      seen_nxt    = seen_r;
      width_nxt   = width_r;
      height_nxt  = height_r;
      rem_nxt     = rem_r;
    end else begin
      r_hit = f_hit;
      if (eof && !(f_hit && (f_kind == ppmhp_pkg::KIND_ERROR))) begin
        if (f_phase != PH_DATA) begin
          r_hit  = 1'b1;
          r_kind = ppmhp_pkg::KIND_ERROR;
          unique case (f_phase)
            PH_SIG0, PH_SIG1: r_code = ppmhp_pkg::ERR_SIG;
            PH_WSKIP:         r_code = ppmhp_pkg::ERR_WIDTH;
            PH_HSKIP:         r_code = ppmhp_pkg::ERR_HEIGHT;
            PH_MSKIP:         r_code = ppmhp_pkg::ERR_MAXVAL;
            PH_WNUM:  r_code = dim_ok_f ? ppmhp_pkg::ERR_HEIGHT : ppmhp_pkg::ERR_WIDTH;
            PH_HNUM:  r_code = dim_ok_f ? ppmhp_pkg::ERR_MAXVAL : ppmhp_pkg::ERR_HEIGHT;
            PH_MNUM:  r_code = max_ok_f ? ppmhp_pkg::ERR_NL : ppmhp_pkg::ERR_MAXVAL;
            default:  r_code = ppmhp_pkg::ERR_SIG;
          endcase
        end else if (f_rem != '0) begin
          r_hit  = 1'b1;
          r_kind = ppmhp_pkg::KIND_ERROR;
          r_code = ppmhp_pkg::ERR_DSIZE;
        end
      end
      if (!eof && r_hit && (r_kind == ppmhp_pkg::KIND_ERROR)) begin
        err_nxt = 1'b1;
      end
    end
    // end of file starts the next file from reset
    if (eof) begin
      phase_nxt   = PH_SIG0;
      comment_nxt = 1'b0;
      acc_nxt     = '0;
      neg_nxt     = 1'b0;
      seen_nxt    = 1'b0;
      width_nxt   = '0;
      height_nxt  = '0;
      rem_nxt     = '0;
      err_nxt     = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SIG0;
      comment_r <= 1'b0;
      acc_r     <= '0;
      neg_r     <= 1'b0;
      seen_r    <= 1'b0;
      width_r   <= '0;
      height_r  <= '0;
      rem_r     <= '0;
      err_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      comment_r <= comment_nxt;
      acc_r     <= acc_nxt;
      neg_r     <= neg_nxt;
      seen_r    <= seen_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      rem_r     <= rem_nxt;
      err_r     <= err_nxt;
    end
  end

  // result word
  assign w_ext = {16'b0, width_r};
  assign h_ext = {16'b0, height_r};

  always_comb begin
    res      = '0;
    res.hit  = r_hit;
    res.word.kind      = r_kind;
    res.word.final_res = eof;
    case (r_kind)
      ppmhp_pkg::KIND_HEADER: begin
        res.word.image_width  = w_ext[15:0];
        res.word.image_height = h_ext[15:0];
      end
      ppmhp_pkg::KIND_DATA: begin
        res.word.pixel_byte = c;
      end
      default: begin
        res.word.error_code = r_code;
      end
    endcase
  end

  assign status.err_latched = err_r;
  assign status.data_phase  = (phase_r == PH_DATA);

endmodule

// ===== src/ppm_p6_header_parser.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_header_parser
// P6 image header parser with pixel byte pass-through
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one file byte per word with an end-of-file mark, taken at an
//   edge where in_valid is high and in_stall is low.
//   out channel: at most one result word per input word: header dimensions,
//   a pixel byte or an error code; taken when out_valid is high and out_stall
//   is low. final_res marks the word caused by the end-of-file byte.
//   A word is held in the input register, then its result in the result register.
//   Throughput: one byte per cycle while out_stall is low; the parse step is
//   one pass of logic between the input register and the result register.
//   The byte count check loads width * height * 3 from a registered
//   multiplier that runs off the stored dimensions.
//   Reset clears both valid flags and the parse state; in_stall is low after
//   reset. While the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only when both are full.
//   After an error no words come out, not even for the end-of-file byte;
//   each end-of-file byte returns the parser to its reset state.
// ----------------------------------------------------------------------------
`include "ppm_p6_header_parser_macros.svh"

module ppm_p6_header_parser #(
  parameter int MAX_DIM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ppmhp_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ppmhp_pkg::out_word_t out_data
);

  logic                 in_valid_r, in_valid_nxt;
  ppmhp_pkg::in_word_t  in_data_r;
  logic                 out_valid_r, out_valid_nxt;
  ppmhp_pkg::out_word_t out_data_r;
  logic                 adv, fire;
  ppmhp_pkg::res_t      res;
  ppmhp_pkg::status_t   status;
  logic                 err_word, hdr_word;

  // pipeline advance
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  // input register
  assign in_valid_nxt = in_stall ? in_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // parse core
  ppmhp_parse #(
    .MAX_DIM_BITS(MAX_DIM_BITS)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .in_word(in_data_r),
    .res    (res),
    .status (status)
  );

  // result register
  assign out_valid_nxt = adv ? (fire && res.hit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.hit) begin
      out_data_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  assign err_word = out_valid_r && (out_data_r.kind == ppmhp_pkg::KIND_ERROR) &&
                    !out_data_r.final_res;
  assign hdr_word = out_valid_r && (out_data_r.kind == ppmhp_pkg::KIND_HEADER);

  `PPMHP_ASSERT_IMP(a_no_stall_when_empty, !out_valid_r, !in_stall)
  `PPMHP_ASSERT_IMP(a_err_latched, err_word, status.err_latched)
  `PPMHP_ASSERT_IMP(a_header_data, hdr_word, status.data_phase)

endmodule
